/* sv/clis_pkg.sv */
`default_nettype none
package clis_pkg;

    // display geometry and bus masks
    localparam logic [7:0] ROW_OFFSET = 8'd64;
    localparam logic [7:0] HI_MASK    = 8'hF0;
    localparam logic [7:0] LO_MASK    = 8'h0F;

    localparam int PC_W = 4;

    // microprogram entry points
    localparam logic [PC_W-1:0] PC_INIT  = 4'd0;
    localparam logic [PC_W-1:0] PC_DATA  = 4'd10;
    localparam logic [PC_W-1:0] PC_POS   = 4'd11;
    localparam logic [PC_W-1:0] PC_GLYPH = 4'd12;
    localparam logic [PC_W-1:0] PC_CLEAR = 4'd13;
    localparam logic [PC_W-1:0] PC_LAST  = 4'd13;

    // configuration register select (paddr bit 2)
    localparam logic REG_BUS   = 1'b0;
    localparam logic REG_WIDTH = 1'b1;

    localparam logic       RESET_EIGHT = 1'b0;
    localparam logic [5:0] RESET_WIDTH = 6'd16;

    typedef enum logic [2:0] {
        CMD_INIT  = 3'd0,
        CMD_DATA  = 3'd1,
        CMD_POS   = 3'd2,
        CMD_GLYPH = 3'd3,
        CMD_CLEAR = 3'd4
    } t_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_seq_state;

    typedef enum logic {
        SRC_LIT,
        SRC_OPND
    } t_src;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_IF8,
        JMP_END
    } t_jmp;

    // one microword: a single raw strobe, or a byte (one or two strobes by bus mode)
    typedef struct packed {
        logic            raw;
        t_src            src;
        logic            rs;
        logic [7:0]      lit;
        logic [4:0]      wait_ms;
        t_jmp            jmp;
        logic [PC_W-1:0] target;
    } t_uword;

    // sequencer to datapath strobe control
    typedef struct packed {
        logic            valid;
        logic            lo;
        logic            last;
        logic [PC_W-1:0] pc;
    } t_seq_ctl;

    function automatic t_uword mk(input logic raw, input t_src src, input logic rs,
                                  input logic [7:0] lit, input logic [4:0] wait_ms,
                                  input t_jmp jmp, input logic [PC_W-1:0] target);
        t_uword w;
        w.raw     = raw;
        w.src     = src;
        w.rs      = rs;
        w.lit     = lit;
        w.wait_ms = wait_ms;
        w.jmp     = jmp;
        w.target  = target;
        return w;
    endfunction

    // microprogram rom
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            4'd0:    w = mk(1'b1, SRC_LIT, 1'b0, 8'h30, 5'd20, JMP_NEXT, 4'd0);
            4'd1:    w = mk(1'b1, SRC_LIT, 1'b0, 8'h30, 5'd5, JMP_NEXT, 4'd0);
            4'd2:    w = mk(1'b1, SRC_LIT, 1'b0, 8'h30, 5'd1, JMP_NEXT, 4'd0);
            4'd3:    w = mk(1'b1, SRC_LIT, 1'b0, 8'h30, 5'd0, JMP_IF8, 4'd6);
            4'd4:    w = mk(1'b1, SRC_LIT, 1'b0, 8'h20, 5'd0, JMP_NEXT, 4'd0);
            4'd5:    w = mk(1'b0, SRC_LIT, 1'b0, 8'h28, 5'd0, JMP_ALWAYS, 4'd7);
            4'd6:    w = mk(1'b0, SRC_LIT, 1'b0, 8'h38, 5'd0, JMP_NEXT, 4'd0);
            4'd7:    w = mk(1'b0, SRC_LIT, 1'b0, 8'h0C, 5'd0, JMP_NEXT, 4'd0);
            4'd8:    w = mk(1'b0, SRC_LIT, 1'b0, 8'h01, 5'd2, JMP_NEXT, 4'd0);
            4'd9:    w = mk(1'b0, SRC_LIT, 1'b0, 8'h06, 5'd2, JMP_END, 4'd0);
            4'd10:   w = mk(1'b0, SRC_OPND, 1'b1, 8'h00, 5'd0, JMP_END, 4'd0);
            4'd11:   w = mk(1'b0, SRC_OPND, 1'b0, 8'h00, 5'd0, JMP_END, 4'd0);
            4'd12:   w = mk(1'b0, SRC_OPND, 1'b0, 8'h00, 5'd0, JMP_END, 4'd0);
            4'd13:   w = mk(1'b0, SRC_LIT, 1'b0, 8'h01, 5'd2, JMP_END, 4'd0);
            default: w = mk(1'b0, SRC_LIT, 1'b0, 8'h00, 5'd0, JMP_END, 4'd0);
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

/* sv/clis_ifs.sv */
`default_nettype none
// request channel
interface clis_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] char_value;
    logic [5:0] column;
    logic       row;
    logic [2:0] glyph;
    modport source (output valid, cmd, char_value, column, row, glyph, input ready);
    modport sink (input valid, cmd, char_value, column, row, glyph, output ready);
endinterface

// strobe channel
interface clis_res_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic [7:0] bus_value;
    logic [4:0] wait_ms;
    logic       last;
    modport source (output valid, reg_select, bus_value, wait_ms, last, input ready);
    modport sink (input valid, reg_select, bus_value, wait_ms, last, output ready);
endinterface
`default_nettype wire

/* sv/char_lcd_interface_sequencer.sv */
// first strobe beat: the state register enters run on accept, and the beat is then
//   loaded into the output register; throughput: one strobe beat per cycle while the
//   sink is ready (init 13 strobes on a 4-bit bus, 8 on 8-bit)
// the microcode step counter handles one request at a time; the next request can be
//   taken in the cycle after the one that issues the previous request's last strobe
// reset (synchronous, active low): 4-bit bus, width 16, cursor 0, glyph mode
`default_nettype none
module char_lcd_interface_sequencer (
    input  wire        i_clk,
    input  wire        i_rst_n,
    clis_cmd_if.sink   i_cmd_ch,
    clis_res_if.source o_res_ch,
    input  wire        psel,
    input  wire        penable,
    input  wire        pwrite,
    input  wire  [2:0] paddr,
    input  wire [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);

    logic                        r_eight_bit;
    logic [5:0]                  r_screen_width;
    logic                        w_cfg_wr;
    logic                        w_accept;
    logic                        w_busy;
    logic                        w_start;
    logic [clis_pkg::PC_W-1:0]   w_entry;
    logic                        w_emit_ok;
    clis_pkg::t_seq_ctl          w_ctl;

    // configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eight_bit    <= clis_pkg::RESET_EIGHT;
            r_screen_width <= clis_pkg::RESET_WIDTH;
        end else if (w_cfg_wr) begin
            if (paddr[2] == clis_pkg::REG_BUS) begin
                r_eight_bit <= pwdata[0];
            end else begin
                r_screen_width <= pwdata[5:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == clis_pkg::REG_BUS) begin
            prdata = {31'd0, r_eight_bit};
        end else begin
            prdata = {26'd0, r_screen_width};
        end
    end

    // request handshake
    assign i_cmd_ch.ready = !w_busy;
    assign w_accept       = i_cmd_ch.valid && i_cmd_ch.ready;

    clis_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_entry     (w_entry),
        .i_eight_bit (r_eight_bit),
        .i_emit_ok   (w_emit_ok),
        .o_busy      (w_busy),
        .o_ctl       (w_ctl)
    );

    clis_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_cmd          (i_cmd_ch.cmd),
        .i_char_value   (i_cmd_ch.char_value),
        .i_column       (i_cmd_ch.column),
        .i_row          (i_cmd_ch.row),
        .i_glyph        (i_cmd_ch.glyph),
        .i_eight_bit    (r_eight_bit),
        .i_screen_width (r_screen_width),
        .i_ctl          (w_ctl),
        .i_out_ready    (o_res_ch.ready),
        .o_start        (w_start),
        .o_entry        (w_entry),
        .o_emit_ok      (w_emit_ok),
        .o_out_valid    (o_res_ch.valid),
        .o_reg_select   (o_res_ch.reg_select),
        .o_bus_value    (o_res_ch.bus_value),
        .o_wait_ms      (o_res_ch.wait_ms),
        .o_last         (o_res_ch.last)
    );

`ifndef SYNTH
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !w_accept)
        else $error("request accepted while a program runs");
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.last |=> i_cmd_ch.ready)
        else $error("not ready after last strobe");
    a_wait_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_ch.valid |-> o_res_ch.wait_ms <= 5'd20)
        else $error("wait out of range");
`endif

endmodule
`default_nettype wire

/* sv/clis_seq.sv */
`default_nettype none
module clis_seq (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_start,
    input  wire  [clis_pkg::PC_W-1:0]       i_entry,
    input  wire                             i_eight_bit,
    input  wire                             i_emit_ok,
    output logic                            o_busy,
    output clis_pkg::t_seq_ctl              o_ctl
);

    clis_pkg::t_seq_state        r_state, n_state;
    logic [clis_pkg::PC_W-1:0]   r_pc, n_pc;
    logic                        r_lo, n_lo;
    clis_pkg::t_uword            w_word;
    logic                        w_fire;
    logic                        w_two;
    logic                        w_word_done;
    logic                        w_end;
    logic                        w_take;

    // current microword and strobe decode
    always_comb begin
        w_word      = clis_pkg::ucode(r_pc);
        w_fire      = (r_state == clis_pkg::ST_RUN) && i_emit_ok;
        w_two       = !w_word.raw && !i_eight_bit;
        w_word_done = !w_two || r_lo;
        w_end       = w_word.jmp == clis_pkg::JMP_END;
        w_take      = (w_word.jmp == clis_pkg::JMP_ALWAYS) ||
                      ((w_word.jmp == clis_pkg::JMP_IF8) && i_eight_bit);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            clis_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = clis_pkg::ST_RUN;
                end
            end
            clis_pkg::ST_RUN: begin
                if (w_fire && w_word_done && w_end) begin
                    n_state = clis_pkg::ST_IDLE;
                end
            end
            default: n_state = clis_pkg::ST_IDLE;
        endcase
    end

    // step counter and nibble phase
    always_comb begin
        n_pc = r_pc;
        n_lo = r_lo;
        if (r_state == clis_pkg::ST_IDLE) begin
            n_lo = 1'b0;
            if (i_start) begin
                n_pc = i_entry;
            end
        end else if (w_fire) begin
            if (!w_word_done) begin
                n_lo = 1'b1;
            end else begin
                n_lo = 1'b0;
                if (w_take) begin
                    n_pc = w_word.target;
                end else if (!w_end) begin
                    n_pc = r_pc + 1'b1;
                end
            end
        end
    end

    // outputs
    always_comb begin
        o_busy      = r_state == clis_pkg::ST_RUN;
        o_ctl.valid = w_fire;
        o_ctl.lo    = r_lo;
        o_ctl.last  = w_fire && w_word_done && w_end;
        o_ctl.pc    = r_pc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clis_pkg::ST_IDLE;
            r_pc    <= clis_pkg::PC_INIT;
            r_lo    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_lo    <= n_lo;
        end
    end

`ifndef SYNTH
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == clis_pkg::ST_IDLE)
        else $error("start while sequencer busy");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.last |=> r_state == clis_pkg::ST_IDLE)
        else $error("sequencer still running after last strobe");
    a_lo_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo |-> r_state == clis_pkg::ST_RUN)
        else $error("low nibble phase outside a program");
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == clis_pkg::ST_RUN |-> r_pc <= clis_pkg::PC_LAST)
        else $error("step counter beyond program");
`endif

endmodule
`default_nettype wire

/* sv/clis_dpath.sv */
`default_nettype none
module clis_dpath (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_accept,
    input  wire  [2:0]                      i_cmd,
    input  wire  [7:0]                      i_char_value,
    input  wire  [5:0]                      i_column,
    input  wire                             i_row,
    input  wire  [2:0]                      i_glyph,
    input  wire                             i_eight_bit,
    input  wire  [5:0]                      i_screen_width,
    input  clis_pkg::t_seq_ctl              i_ctl,
    input  wire                             i_out_ready,
    output logic                            o_start,
    output logic [clis_pkg::PC_W-1:0]       o_entry,
    output logic                            o_emit_ok,
    output logic                            o_out_valid,
    output logic                            o_reg_select,
    output logic [7:0]                      o_bus_value,
    output logic [4:0]                      o_wait_ms,
    output logic                            o_last
);

    logic [5:0]       r_cursor, n_cursor;
    logic             r_ddram, n_ddram;
    logic [7:0]       r_opnd, n_opnd;
    logic             r_out_valid;
    logic             r_out_rs;
    logic [7:0]       r_out_bus;
    logic [4:0]       r_out_wait;
    logic             r_out_last;
    logic             w_go;
    logic [7:0]       w_pos;
    clis_pkg::t_uword w_word;
    logic [7:0]       w_byte;
    logic [7:0]       w_bus;
    logic [4:0]       w_wait;

    // position command byte, kept to 8 bits
    assign w_pos = 8'h80 + (i_row ? clis_pkg::ROW_OFFSET : 8'h00) + {2'b00, i_column};

    // dispatch and cursor bookkeeping
    always_comb begin
        w_go     = 1'b0;
        o_entry  = clis_pkg::PC_INIT;
        n_cursor = r_cursor;
        n_ddram  = r_ddram;
        n_opnd   = r_opnd;
        case (clis_pkg::t_cmd'(i_cmd))
            clis_pkg::CMD_INIT: begin
                w_go = 1'b1;
            end
            clis_pkg::CMD_DATA: begin
                o_entry = clis_pkg::PC_DATA;
                w_go    = !r_ddram || (r_cursor < i_screen_width);
                n_opnd  = i_char_value;
                if (w_go && r_ddram) begin
                    n_cursor = r_cursor + 1'b1;
                end
            end
            clis_pkg::CMD_POS: begin
                o_entry  = clis_pkg::PC_POS;
                w_go     = 1'b1;
                n_opnd   = w_pos;
                n_ddram  = 1'b1;
                n_cursor = i_column;
            end
            clis_pkg::CMD_GLYPH: begin
                o_entry = clis_pkg::PC_GLYPH;
                w_go    = 1'b1;
                n_opnd  = 8'h40 + {2'b00, i_glyph, 3'b000};
                n_ddram = 1'b0;
            end
            clis_pkg::CMD_CLEAR: begin
                o_entry = clis_pkg::PC_CLEAR;
                w_go    = 1'b1;
            end
            default: begin
                w_go = 1'b0;
            end
        endcase
        o_start = i_accept && w_go;
    end

    // strobe byte: whole byte, high nibble or low nibble
    always_comb begin
        w_word = clis_pkg::ucode(i_ctl.pc);
        w_byte = (w_word.src == clis_pkg::SRC_OPND) ? r_opnd : w_word.lit;
        if (w_word.raw || i_eight_bit) begin
            w_bus  = w_byte;
            w_wait = w_word.wait_ms;
        end else if (!i_ctl.lo) begin
            w_bus  = w_byte & clis_pkg::HI_MASK;
            w_wait = 5'd0;
        end else begin
            w_bus  = {w_byte[3:0] & clis_pkg::LO_MASK[3:0], 4'h0};
            w_wait = w_word.wait_ms;
        end
    end

    assign o_emit_ok    = !r_out_valid || i_out_ready;
    assign o_out_valid  = r_out_valid;
    assign o_reg_select = r_out_rs;
    assign o_bus_value  = r_out_bus;
    assign o_wait_ms    = r_out_wait;
    assign o_last       = r_out_last;

    // state and operand registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= 6'd0;
            r_ddram  <= 1'b0;
        end else if (i_accept) begin
            r_cursor <= n_cursor;
            r_ddram  <= n_ddram;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_opnd <= n_opnd;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_out_rs   <= w_word.rs;
            r_out_bus  <= w_bus;
            r_out_wait <= w_wait;
            r_out_last <= i_ctl.last;
        end
    end

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.valid |-> (!r_out_valid || i_out_ready))
        else $error("strobe loaded over a pending beat");
    a_cursor_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_start && i_cmd == clis_pkg::CMD_DATA && r_ddram)
        |=> r_cursor == $past(r_cursor) + 6'd1)
        else $error("cursor did not advance on data write");
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_cursor) && $stable(r_ddram))
        else $error("cursor state changed without a request");
`endif

endmodule
`default_nettype wire
